### hw/rtl/pfde_pkg.sv
// Package of the page framebuffer draw engine: command codes, job and result
// types shared by the front end, the back end and the top level.
// Depends on nothing.
`default_nettype none

package pfde_pkg;

  typedef enum logic [3:0] {
    CMD_PIXEL   = 4'd0,
    CMD_HLINE   = 4'd1,
    CMD_DHLINE  = 4'd2,
    CMD_VLINE   = 4'd3,
    CMD_DVLINE  = 4'd4,
    CMD_OUTLINE = 4'd5,
    CMD_FILL    = 4'd6,
    CMD_INVERT  = 4'd7,
    CMD_INVSEG  = 4'd8,
    CMD_CLRSEG  = 4'd9,
    CMD_WRBYTE  = 4'd10,
    CMD_RDBYTE  = 4'd11,
    CMD_CLEAR   = 4'd12
  } cmd_e;

  // Operation that the back end applies to every byte of a job.
  typedef enum logic [2:0] {
    OP_CLR   = 3'd0,
    OP_SET   = 3'd1,
    OP_INV   = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_WIPE  = 3'd5,
    OP_NOP   = 3'd6
  } op_e;

  // States of the back end's byte walk.
  typedef enum logic [2:0] {
    B_WIPE, B_IDLE, B_ACCESS, B_MODIFY, B_DONE
  } back_state_e;

  // One rectangular job: columns x0..x1, rows y0..y1, both inclusive.
  typedef struct packed {
    op_e        op;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [6:0] y0;
    logic [6:0] y1;
    logic       dx2;
    logic       dy2;
    logic       empty;
    logic [7:0] value;
    logic       last;
  } job_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       was_read;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  localparam int unsigned OutlineJobs = 8;

endpackage

`default_nettype wire

### hw/rtl/page_framebuffer_draw_engine.sv
// Top level of the page framebuffer draw engine: front end, job queue,
// back end with the framebuffer RAM, and result queue. Depends on pfde_pkg.
//
// Usage: commands enter through a queue-like port. An item is taken at a
// rising edge of clk_i with push high and full low. Results leave through a
// second queue-like port: while empty is low the oldest result is on
// read_data_o and was_read_o, and it is taken at an edge with pop high.
// Every command gives exactly one result; only a byte read carries data.
//
// Timing: the framebuffer lives in one RAM with a registered read port, and
// every touched byte is read in the access state and written in the modify
// state of the back end; a byte read captures the byte instead of writing
// it. Bytes outside the store are skipped without a write. An outline is
// eight jobs. Clear-all writes one byte a cycle. The front end takes one
// command at a time, so full is high while a command is still being decoded.
//
// Reset: the store is cleared by a pass over all COLUMNS * PAGES bytes
// (1024 at the default size) after rst_ni rises; full stays high for that pass.
// A stalled receiver fills the two-entry result queue; the back end then
// holds its finished command and the job queue and front end back up.
`default_nettype none

module page_framebuffer_draw_engine #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output      logic       full,
  input  wire logic [3:0] command_i,
  input  wire logic [6:0] x_start_i,
  input  wire logic [5:0] y_start_i,
  input  wire logic [6:0] x_end_i,
  input  wire logic [5:0] y_end_i,
  input  wire logic       color_i,
  input  wire logic [2:0] page_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       pop,
  output      logic       empty,
  output      logic [7:0] read_data_o,
  output      logic       was_read_o
);
  import pfde_pkg::*;

  back_stat_t stat;
  job_t       front_job, head_job;
  logic       job_push, job_full, job_pop, job_empty;
  logic [$bits(job_t)-1:0] head_job_bits;
  res_t       back_res, out_res;
  logic       res_push, res_full;
  logic [$bits(res_t)-1:0] out_res_bits;

  // The front end decodes a command into rectangle jobs.
  pfde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .color_i     (color_i),
    .page_i      (page_i),
    .byte_value_i(byte_value_i),
    .stat_i      (stat),
    .job_push_o  (job_push),
    .job_o       (front_job),
    .job_full_i  (job_full)
  );

  // The job queue lets decode run ahead of the byte walk.
  pfde_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(2)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(front_job),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(head_job_bits),
    .empty_o(job_empty)
  );

  assign head_job = job_t'(head_job_bits);

  pfde_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_i      (head_job),
    .job_pop_o  (job_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (back_res),
    .stat_o     (stat)
  );

  // Results wait here until the receiver pops them.
  pfde_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(out_res_bits),
    .empty_o(empty)
  );

  assign out_res     = res_t'(out_res_bits);
  assign read_data_o = out_res.read_data;
  assign was_read_o  = out_res.was_read;

endmodule

`default_nettype wire

### hw/rtl/pfde_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/pfde_fifo.sv
// Small register FIFO used for the job queue and the result queue.
// Depends on nothing.
`default_nettype none

module pfde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pfde_front.sv
// Front end: takes command items, decodes each into one or more rectangle jobs
// and pushes them into the job queue. Depends on pfde_pkg.
`default_nettype none

module pfde_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  output      logic                 full_o,
  input  wire logic [3:0]           command_i,
  input  wire logic [6:0]           x_start_i,
  input  wire logic [5:0]           y_start_i,
  input  wire logic [6:0]           x_end_i,
  input  wire logic [5:0]           y_end_i,
  input  wire logic                 color_i,
  input  wire logic [2:0]           page_i,
  input  wire logic [7:0]           byte_value_i,
  input  wire pfde_pkg::back_stat_t stat_i,
  output      logic                 job_push_o,
  output      pfde_pkg::job_t       job_o,
  input  wire logic                 job_full_i
);
  import pfde_pkg::*;

  logic       busy_q, busy_d;
  logic [2:0] sub_q, sub_d;
  logic [3:0] cmd_q;
  logic [6:0] xs_q, xe_q;
  logic [5:0] ys_q, ye_q;
  logic       col_q;
  logic [2:0] pg_q;
  logic [7:0] val_q;
  logic       accept;

  assign full_o = busy_q || stat_i.init_busy;
  assign accept = push_i && !full_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      xs_q  <= x_start_i;
      ys_q  <= y_start_i;
      xe_q  <= x_end_i;
      ye_q  <= y_end_i;
      col_q <= color_i;
      pg_q  <= page_i;
      val_q <= byte_value_i;
    end
  end

  // Job decode for the stored command and its sub-step.
  always_comb begin
    logic [7:0] xs8, xe8;
    logic [6:0] ys7, ye7;
    logic       edge_job;
    op_e        draw_op;
    xs8      = {1'b0, xs_q};
    xe8      = {1'b0, xe_q};
    ys7      = {1'b0, ys_q};
    ye7      = {1'b0, ye_q};
    draw_op  = col_q ? OP_SET : OP_CLR;
    edge_job = 1'b0;
    job_o.op    = OP_NOP;
    job_o.x0    = xs8;
    job_o.x1    = xe8;
    job_o.y0    = ys7;
    job_o.y1    = ye7;
    job_o.dx2   = 1'b0;
    job_o.dy2   = 1'b0;
    job_o.empty = 1'b0;
    job_o.value = val_q;
    job_o.last  = 1'b1;
    unique case (cmd_e'(cmd_q))
      CMD_PIXEL: begin
        job_o.op = draw_op;
        job_o.x1 = xs8;
        job_o.y1 = ys7;
      end
      CMD_HLINE, CMD_DHLINE: begin
        job_o.op  = draw_op;
        job_o.y1  = ys7;
        job_o.dx2 = (cmd_e'(cmd_q) == CMD_DHLINE);
      end
      CMD_VLINE, CMD_DVLINE: begin
        job_o.op  = draw_op;
        job_o.x1  = xs8;
        job_o.dy2 = (cmd_e'(cmd_q) == CMD_DVLINE);
      end
      CMD_OUTLINE: begin
        job_o.op   = draw_op;
        job_o.last = (sub_q == 3'(OutlineJobs - 1));
        unique case (sub_q)
          3'd0: begin job_o.x1 = xs8; job_o.y1 = ys7; end
          3'd1: begin job_o.x1 = xs8; job_o.y0 = ye7; end
          3'd2: begin job_o.x0 = xe8; job_o.y1 = ys7; end
          3'd3: begin job_o.x0 = xe8; job_o.y0 = ye7; end
          3'd4, 3'd5: begin
            // Top and bottom edges run strictly between the corners.
            edge_job    = 1'b1;
            job_o.x0    = xs8 + 8'd1;
            job_o.x1    = xe8 - 8'd1;
            job_o.y0    = (sub_q == 3'd4) ? ys7 : ye7;
            job_o.y1    = (sub_q == 3'd4) ? ys7 : ye7;
            job_o.empty = (xs8 + 8'd1) >= xe8;
          end
          default: begin
            edge_job    = 1'b1;
            job_o.x0    = (sub_q == 3'd6) ? xs8 : xe8;
            job_o.x1    = (sub_q == 3'd6) ? xs8 : xe8;
            job_o.y0    = ys7 + 7'd1;
            job_o.y1    = ye7 - 7'd1;
            job_o.empty = (ys7 + 7'd1) >= ye7;
          end
        endcase
      end
      CMD_FILL: job_o.op = draw_op;
      CMD_INVERT: job_o.op = OP_INV;
      CMD_INVSEG, CMD_CLRSEG: begin
        job_o.op = (cmd_e'(cmd_q) == CMD_INVSEG) ? OP_INV : OP_CLR;
        job_o.y0 = {1'b0, pg_q, 3'b000};
        job_o.y1 = {1'b0, pg_q, 3'b111};
      end
      CMD_WRBYTE, CMD_RDBYTE: begin
        job_o.op = (cmd_e'(cmd_q) == CMD_WRBYTE) ? OP_WRITE : OP_READ;
        job_o.x1 = xs8;
        job_o.y0 = {1'b0, pg_q, 3'b000};
        job_o.y1 = {1'b0, pg_q, 3'b000};
      end
      CMD_CLEAR: job_o.op = OP_WIPE;
      default: job_o.op = OP_NOP;
    endcase
    if (!edge_job) begin
      job_o.empty = (job_o.x0 > job_o.x1) || (job_o.y0 > job_o.y1);
    end
  end

  assign job_push_o = busy_q && !job_full_i;

  always_comb begin
    busy_d = busy_q;
    sub_d  = sub_q;
    if (accept) begin
      busy_d = 1'b1;
      sub_d  = '0;
    end else if (job_push_o) begin
      if (job_o.last) begin
        busy_d = 1'b0;
      end else begin
        sub_d = sub_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sub_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sub_q  <= sub_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pfde_back.sv
// Back end: walks each job byte by byte over the framebuffer RAM with
// read-modify-write steps, clears the store, and emits one result per command.
// Depends on pfde_pkg, pfde_ram.
`default_nettype none

module pfde_back #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 job_valid_i,
  input  wire pfde_pkg::job_t       job_i,
  output      logic                 job_pop_o,
  input  wire logic                 res_full_i,
  output      logic                 res_push_o,
  output      pfde_pkg::res_t       res_o,
  output      pfde_pkg::back_stat_t stat_o
);
  import pfde_pkg::*;

  localparam int Depth = COLUMNS * PAGES;
  localparam int AW    = $clog2(Depth);

  back_state_e   st_q, st_d;
  logic [7:0]    x_q, x_d;
  logic [2:0]    p_q, p_d;
  logic [7:0]    rd_q, rd_d;
  logic          init_q, init_d;
  logic [AW-1:0] wcnt_q, wcnt_d;

  logic          addr_ok;
  logic [AW-1:0] addr;
  logic [7:0]    mask, rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [8:0]    nx;
  logic          adv_done;

  assign addr_ok = (32'(x_q) < COLUMNS) && (32'(p_q) < PAGES);
  assign addr    = AW'(32'(p_q) * COLUMNS + 32'(x_q));
  assign stat_o.init_busy = init_q;

  // Rows of the current page that fall into the job, honoring dotted rows.
  always_comb begin
    logic [5:0] yv;
    yv   = '0;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      yv      = {p_q, 3'(b)};
      mask[b] = ({1'b0, yv} >= job_i.y0) && ({1'b0, yv} <= job_i.y1) &&
                (!job_i.dy2 || (yv[0] == job_i.y0[0]));
    end
  end

  assign nx       = {1'b0, x_q} + (job_i.dx2 ? 9'd2 : 9'd1);
  assign adv_done = (nx > {1'b0, job_i.x1}) && (p_q == job_i.y1[5:3]);

  pfde_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_comb begin
    st_d       = st_q;
    x_d        = x_q;
    p_d        = p_q;
    rd_d       = rd_q;
    init_d     = init_q;
    wcnt_d     = wcnt_q;
    we         = 1'b0;
    waddr      = addr;
    wdata      = '0;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.read_data = rd_q;
    res_o.was_read  = (job_i.op == OP_READ);
    unique case (st_q)
      B_WIPE: begin
        we     = 1'b1;
        waddr  = wcnt_q;
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == AW'(Depth - 1)) begin
          init_d = 1'b0;
          st_d   = init_q ? B_IDLE : B_DONE;
        end
      end
      B_IDLE: begin
        if (job_valid_i) begin
          x_d  = job_i.x0;
          p_d  = job_i.y0[5:3];
          rd_d = '0;
          if (job_i.op == OP_WIPE) begin
            wcnt_d = '0;
            st_d   = B_WIPE;
          end else if (job_i.op == OP_NOP || job_i.empty) begin
            st_d = B_DONE;
          end else begin
            st_d = B_ACCESS;
          end
        end
      end
      B_ACCESS, B_MODIFY: begin
        if (st_q == B_ACCESS && addr_ok) begin
          st_d = B_MODIFY;
        end else begin
          if (st_q == B_MODIFY) begin
            we = 1'b1;
            unique case (job_i.op)
              OP_CLR:   wdata = rdata & ~mask;
              OP_SET:   wdata = rdata | mask;
              OP_INV:   wdata = rdata ^ mask;
              OP_WRITE: wdata = job_i.value;
              default: begin
                we   = 1'b0;
                rd_d = rdata;
              end
            endcase
          end
          if (adv_done) begin
            st_d = B_DONE;
          end else if (nx > {1'b0, job_i.x1}) begin
            p_d  = p_q + 3'd1;
            x_d  = job_i.x0;
            st_d = B_ACCESS;
          end else begin
            x_d  = nx[7:0];
            st_d = B_ACCESS;
          end
        end
      end
      B_DONE: begin
        if (!job_i.last || !res_full_i) begin
          res_push_o = job_i.last;
          job_pop_o  = 1'b1;
          st_d       = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_WIPE;
      init_q <= 1'b1;
      wcnt_q <= '0;
    end else begin
      st_q   <= st_d;
      init_q <= init_d;
      wcnt_q <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    p_q  <= p_d;
    rd_q <= rd_d;
  end

endmodule

`default_nettype wire

### hw/rtl/pfde_checker.sv
// Port-level checker for the draw engine and the bind that attaches it.
// Depends on page_framebuffer_draw_engine.
`default_nettype none

module pfde_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic [7:0] read_data_o,
  input wire logic       was_read_o
);

  // Only a byte read returns data.
  a_zero_unless_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !was_read_o |-> read_data_o == 8'd0)
    else $error("nonzero data on a result that is not a read");

  // A taken command keeps the input side closed while it is decoded.
  a_full_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("input side open right after a command was taken");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result withdrawn");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(read_data_o) && $stable(was_read_o))
    else $error("waiting result changed");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (.*);

`default_nettype wire
